// ===== rtl/core/mtcu_pkg.sv =====
// Package for the magnetic stripe track character unpacker.
// Holds the item types, format constants and the group decode function.
// No dependencies.
`default_nettype none

package mtcu_pkg;

    localparam int CHAR_W      = 7;
    localparam int COUNT_W     = 9;
    localparam int NUM_CHARS   = 8;
    localparam int IDX_W       = 3;
    localparam int GROUP_MAX   = 7;
    localparam int MAX_TRACK_BYTES_DEF = 256;

    localparam logic       FMT_7BIT  = 1'b0;
    localparam logic       FMT_5BIT  = 1'b1;
    localparam logic [2:0] GROUP_7   = 3'd7;
    localparam logic [2:0] GROUP_5   = 3'd5;
    localparam logic [CHAR_W-1:0]  OFFSET_7  = 7'h20;
    localparam logic [CHAR_W-1:0]  OFFSET_5  = 7'h30;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
    localparam logic [IDX_W-1:0]   IDX_LAST  = 3'd7;
    localparam logic [IDX_W-1:0]   IDX_FIRST = 3'd0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0]  decoded_char;
        logic               char_valid;
        logic               track_end;
        logic [COUNT_W-1:0] decoded_count;
    } t_out;

    typedef logic [NUM_CHARS-1:0][CHAR_W-1:0] t_chars;

    // One batch of results handed from the collector to the emitter.
    typedef struct packed {
        t_chars             chars;
        logic [COUNT_W-1:0] base_count;
        logic [IDX_W-1:0]   last_idx;
        logic               has_chars;
        logic               track_end;
    } t_batch;

    // Cuts a group (bytes in stream order, first byte in the top bits) into
    // eight characters. In 5-bit mode only the top 40 bits are used.
    function automatic t_chars decode_group(input logic [GROUP_MAX*8-1:0] bits,
                                            input logic fmt);
        t_chars     res;
        logic [5:0] val;
        int         pos;
        for (int k = 0; k < NUM_CHARS; k++) begin
            val = '0;
            for (int i = 0; i < 6; i++) begin
                if (fmt == FMT_5BIT) begin
                    pos = k * 5 + i;
                    if (i < 4) begin
                        val[i] = bits[GROUP_MAX*8-1-pos];
                    end
                end else begin
                    pos = k * 7 + i;
                    val[i] = bits[GROUP_MAX*8-1-pos];
                end
            end
            res[k] = {1'b0, val} + ((fmt == FMT_5BIT) ? OFFSET_5 : OFFSET_7);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mtcu_front.sv =====
// Byte collector: gathers track bytes into groups, tracks the stop, byte
// and character counts, and decodes a full group into a result batch.
// Depends on mtcu_pkg.
`default_nettype none

module mtcu_front #(
    parameter int MAX_TRACK_BYTES = mtcu_pkg::MAX_TRACK_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fmt,
    input  wire logic           i_in_valid,
    input  wire mtcu_pkg::t_in  i_in_data,
    output logic                o_in_stall,
    input  wire logic           i_batch_free,
    output logic                o_load,
    output mtcu_pkg::t_batch    o_batch
);
    import mtcu_pkg::*;

    localparam int BW = $clog2(MAX_TRACK_BYTES + 1);

    logic [GROUP_MAX-1:0][7:0] r_buf;
    logic [2:0]                r_pos, n_pos;
    logic                      r_stopped, n_stopped;
    logic [COUNT_W-1:0]        r_count, n_count;
    logic [BW-1:0]             r_bytes, n_bytes;

    logic [GROUP_MAX-1:0][7:0] merged;
    logic [GROUP_MAX*8-1:0]    group_bits;
    logic [2:0]                gsize;
    logic [3:0]                pos_inc;
    logic                      active, complete, zero_hdr, do_decode, produce, accept;
    logic [COUNT_W:0]          count_sum;

    always_comb begin
        gsize  = (i_fmt == FMT_5BIT) ? GROUP_5 : GROUP_7;
        active = !r_stopped && (r_bytes < BW'(MAX_TRACK_BYTES));
        pos_inc = {1'b0, r_pos} + 4'd1;
        complete = active && (pos_inc >= {1'b0, gsize});
        for (int j = 0; j < GROUP_MAX; j++) begin
            merged[j] = (r_pos == 3'(j)) ? i_in_data.data_byte : r_buf[j];
        end
        for (int j = 0; j < GROUP_MAX; j++) begin
            group_bits[GROUP_MAX*8-1-8*j -: 8] = merged[j];
        end
        zero_hdr  = (merged[0] == 8'd0) || (merged[1] == 8'd0);
        do_decode = complete && !zero_hdr;
        produce   = do_decode || i_in_data.last_byte;
        o_in_stall = produce && !i_batch_free;
        accept    = i_in_valid && !o_in_stall;
        o_load    = accept && produce;

        o_batch.chars      = decode_group(group_bits, i_fmt);
        o_batch.base_count = r_count;
        o_batch.last_idx   = do_decode ? IDX_LAST : IDX_FIRST;
        o_batch.has_chars  = do_decode;
        o_batch.track_end  = i_in_data.last_byte;

        count_sum = {1'b0, r_count} + (COUNT_W+1)'(NUM_CHARS);

        n_pos     = r_pos;
        n_stopped = r_stopped;
        n_count   = r_count;
        n_bytes   = r_bytes;
        if (i_in_data.last_byte) begin
            n_pos     = '0;
            n_stopped = 1'b0;
            n_count   = '0;
            n_bytes   = '0;
        end else if (active) begin
            n_bytes = r_bytes + BW'(1);
            n_pos   = complete ? 3'd0 : pos_inc[2:0];
            if (complete && zero_hdr) begin
                n_stopped = 1'b1;
            end
            if (do_decode) begin
                n_count = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                          : count_sum[COUNT_W-1:0];
            end
        end
    end

    // Group bytes need no reset: a position is always written before it is read.
    always_ff @(posedge i_clk) begin
        if (accept && active) begin
            r_buf[r_pos] <= i_in_data.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_stopped <= 1'b0;
            r_count   <= '0;
            r_bytes   <= '0;
        end else if (accept) begin
            r_pos     <= n_pos;
            r_stopped <= n_stopped;
            r_count   <= n_count;
            r_bytes   <= n_bytes;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mtcu_emit.sv =====
// Result emitter: holds one batch and moves its results, one per cycle while the
// output is not stalled, into the output register.
// Depends on mtcu_pkg.
`default_nettype none

module mtcu_emit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire mtcu_pkg::t_batch i_batch,
    output logic                  o_batch_free,
    output logic                  o_out_valid,
    output mtcu_pkg::t_out        o_out_data,
    input  wire logic             i_out_stall
);
    import mtcu_pkg::*;

    t_batch           r_batch;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    t_out             r_out, n_out;
    logic             r_out_valid;

    logic             out_free, pop, at_last;
    logic [COUNT_W:0] cnt_sum;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        pop      = r_busy && out_free;
        at_last  = (r_idx == r_batch.last_idx);
        o_batch_free = !r_busy || (pop && at_last);

        cnt_sum = {1'b0, r_batch.base_count} + (COUNT_W+1)'(r_idx) + (COUNT_W+1)'(1);
        n_out.char_valid = r_batch.has_chars;
        n_out.track_end  = r_batch.track_end && at_last;
        if (r_batch.has_chars) begin
            n_out.decoded_char  = r_batch.chars[r_idx];
            n_out.decoded_count = (cnt_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                                : cnt_sum[COUNT_W-1:0];
        end else begin
            n_out.decoded_char  = '0;
            n_out.decoded_count = r_batch.base_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_batch <= i_batch;
        end
        if (pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (pop) begin
                if (at_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/magstripe_track_char_unpack.sv =====
// Top level of the magnetic stripe track character unpacker.
// Depends on mtcu_pkg, mtcu_front and mtcu_emit.
//
// Raw track bytes enter one per cycle unless the input is stalled. A completed
// group (7 bytes in 7-bit mode, 5 in 5-bit mode) is decoded in the same cycle
// into a batch of eight characters, which the emitter then sends out at one item
// per cycle, while the output is not stalled, through an output register; the
// batch register and then the output register lie between the byte that completed
// the group and its first character. The emitter holds one batch, so the byte that
// completes the next group, or a byte marked last, is stalled until the previous
// batch has left. The result rate of one item per cycle, while the output is not
// stalled, sets the sustained input rate. The user must write the format register
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module magstripe_track_char_unpack #(
    parameter int MAX_TRACK_BYTES = mtcu_pkg::MAX_TRACK_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_wdata,
    input  wire logic           i_in_valid,
    input  wire mtcu_pkg::t_in  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output mtcu_pkg::t_out      o_out_data,
    input  wire logic           i_out_stall
);
    import mtcu_pkg::*;

    logic   r_fmt;
    logic   load, batch_free;
    t_batch batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_7BIT;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    mtcu_front #(
        .MAX_TRACK_BYTES(MAX_TRACK_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fmt        (r_fmt),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .i_batch_free (batch_free),
        .o_load       (load),
        .o_batch      (batch)
    );

    mtcu_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_batch      (batch),
        .o_batch_free (batch_free),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mtcu_chk.sv =====
// Port-level checker for the track character unpacker, bound to the top level.
// Depends on mtcu_pkg and magstripe_track_char_unpack.
`default_nettype none

module mtcu_chk (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_cfg_we,
    input wire logic           i_cfg_wdata,
    input wire logic           i_in_valid,
    input wire mtcu_pkg::t_in  i_in_data,
    input wire logic           o_in_stall,
    input wire logic           o_out_valid,
    input wire mtcu_pkg::t_out o_out_data,
    input wire logic           i_out_stall
);
    import mtcu_pkg::*;

    // No item leaves right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output item changed");

    // An item without a character only closes a track.
    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.char_valid |->
            o_out_data.track_end && (o_out_data.decoded_char == '0))
        else $error("empty item is not a track end");

    // A character is counted and sits at or above the smaller offset.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.char_valid |->
            (o_out_data.decoded_count != '0) && (o_out_data.decoded_char >= OFFSET_7))
        else $error("character item out of range");

endmodule

bind magstripe_track_char_unpack mtcu_chk u_mtcu_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_wdata (i_cfg_wdata),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for magstripe_track_char_unpack.
// Drives raw track bytes through the valid/stall ports and checks every decoded
// character against a behavioral predictor. Depends on mtcu_pkg and the RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtcu_pkg::*;

    localparam int TRACK_LIMIT  = MAX_TRACK_BYTES_DEF;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} t_stall_mode;

    logic i_clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    logic in_valid;
    t_in  in_data;
    logic in_stall;
    logic out_valid;
    t_out out_data;
    logic out_stall = 1'b0;

    always #10 i_clk = ~i_clk;

    magstripe_track_char_unpack i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    // Predictor state: a copy of the block's track state and format register.
    logic        fmt_q = FMT_7BIT;
    logic [7:0]  grp_bytes [GROUP_MAX];
    int unsigned grp_pos = 0;
    int unsigned trk_bytes = 0;
    bit          halted = 1'b0;
    logic [8:0]  chars_seen = '0;
    t_out        pending_chars [$];

    logic [7:0]  track_q [$];
    int unsigned errors = 0;
    int unsigned burst_left = 0;
    bit          gaps_off = 1'b0;

    // Works out the characters that one accepted track byte releases.
    function automatic void decode_track_byte(input t_in item);
        int unsigned gsize;
        int unsigned nres;
        logic [55:0] bits;
        logic [5:0]  val;
        t_out        res [NUM_CHARS];
        nres = 0;
        if (!halted && trk_bytes < TRACK_LIMIT) begin
            gsize = (fmt_q == FMT_5BIT) ? GROUP_5 : GROUP_7;
            trk_bytes++;
            if (grp_pos < GROUP_MAX) begin
                grp_bytes[grp_pos] = item.data_byte;
            end
            grp_pos++;
            if (grp_pos >= gsize) begin
                grp_pos = 0;
                if (grp_bytes[0] == 8'd0 || grp_bytes[1] == 8'd0) begin
                    halted = 1'b1;
                end else begin
                    bits = '0;
                    for (int i = 0; i < gsize; i++) begin
                        bits = {bits[47:0], grp_bytes[i]};
                    end
                    // Each field is gsize bits wide; the parity bit at its end is dropped.
                    for (int k = 0; k < NUM_CHARS; k++) begin
                        val = '0;
                        for (int i = 0; i < gsize - 1; i++) begin
                            val[i] = bits[gsize * 8 - 1 - (k * gsize + i)];
                        end
                        if (chars_seen != COUNT_MAX) begin
                            chars_seen++;
                        end
                        res[k].decoded_char  = {1'b0, val} +
                                               ((fmt_q == FMT_5BIT) ? OFFSET_5 : OFFSET_7);
                        res[k].char_valid    = 1'b1;
                        res[k].track_end     = 1'b0;
                        res[k].decoded_count = chars_seen;
                    end
                    nres = NUM_CHARS;
                end
            end
        end
        if (item.last_byte) begin
            if (nres > 0) begin
                res[nres - 1].track_end = 1'b1;
            end else begin
                res[0].decoded_char  = '0;
                res[0].char_valid    = 1'b0;
                res[0].track_end     = 1'b1;
                res[0].decoded_count = chars_seen;
                nres = 1;
            end
            grp_pos    = 0;
            trk_bytes  = 0;
            halted     = 1'b0;
            chars_seen = '0;
        end
        for (int k = 0; k < nres; k++) begin
            pending_chars.push_back(res[k]);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    t_out want_char;

    always @(posedge i_clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, got %0h",
                         $time, out_data);
                errors++;
            end else begin
                want_char = pending_chars.pop_front();
                check_field("decoded_char", want_char.decoded_char, out_data.decoded_char);
                check_field("char_valid", want_char.char_valid, out_data.char_valid);
                check_field("track_end", want_char.track_end, out_data.track_end);
                check_field("decoded_count", want_char.decoded_count, out_data.decoded_count);
            end
        end
    end

    // The receiver picks a new stall behavior each time its phase counter wraps to zero.
    t_stall_mode stall_mode = STALL_NONE;
    logic [7:0]  stall_pat = 8'h00;
    logic [5:0]  stall_phase = '0;

    always @(negedge i_clk) begin
        if (stall_phase == 6'd0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_pat  <= 8'($urandom_range(0, 255));
        end
        stall_phase <= stall_phase + 6'd1;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= stall_pat[stall_phase[2:0]];
        endcase
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    // All driving tasks start and end just after a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        t_in         item;
        gap = 0;
        if (!gaps_off) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item.data_byte = b;
        item.last_byte = last;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        decode_track_byte(in_data);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_char_format(input logic fmt);
        cfg_we    <= 1'b1;
        cfg_wdata <= fmt;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        fmt_q = fmt;
    endtask

    // Queues the n low bytes of w, most significant first.
    function automatic void push_bytes(input logic [55:0] w, input int n);
        for (int i = 0; i < n; i++) begin
            track_q.push_back(w[8 * (n - 1 - i) +: 8]);
        end
    endfunction

    task automatic send_track_q(input bit end_track);
        logic [7:0] b;
        while (track_q.size() != 0) begin
            b = track_q.pop_front();
            send_byte(b, end_track && track_q.size() == 0);
        end
    endtask

    // Format left at its reset value; a trailing partial group is dropped.
    task automatic test_seven_bit_groups();
        push_bytes(56'hFFFFFFFFFFFFFF, 7);
        push_bytes(56'h80402010080402, 7);
        push_bytes(56'h01FE55, 3);
        send_track_q(1'b1);
        drain_results();
    endtask

    task automatic test_end_on_group();
        push_bytes(56'hAA55AA55AA55AA, 7);
        send_track_q(1'b1);
        drain_results();
    endtask

    // A zero in the first or second byte of a group halts the track.
    task automatic test_halt_on_zero();
        push_bytes(56'h00FFFFFFFFFFFF, 7);
        push_bytes(56'h1234, 2);
        send_track_q(1'b1);
        push_bytes(56'h7F3C91E2485A0F, 7);
        push_bytes(56'h1200FFFFFF, 5);
        push_bytes(56'h6789, 2);
        send_track_q(1'b1);
        drain_results();
    endtask

    task automatic test_five_bit_groups();
        set_char_format(FMT_5BIT);
        push_bytes(56'hFFFFFFFFFF, 5);
        push_bytes(56'h0102040810, 5);
        send_track_q(1'b1);
        push_bytes(56'h00, 1);
        send_track_q(1'b1);
        drain_results();
    endtask

    // The group size follows the format in force when each byte arrives.
    task automatic test_format_switch();
        set_char_format(FMT_7BIT);
        push_bytes(56'hC3A5F00F96, 5);
        send_track_q(1'b0);
        drain_results();
        set_char_format(FMT_5BIT);
        push_bytes(56'h5A, 1);
        send_track_q(1'b0);
        push_bytes(56'hE7187E, 3);
        send_track_q(1'b0);
        drain_results();
        set_char_format(FMT_7BIT);
        push_bytes(56'h55AA33CC, 4);
        send_track_q(1'b0);
        push_bytes(56'hB4, 1);
        send_track_q(1'b1);
        drain_results();
    endtask

    // Bytes past the track limit are ignored, but the last one still ends it.
    task automatic test_overlong_track();
        logic [7:0] b;
        set_char_format(FMT_5BIT);
        for (int i = 0; i < TRACK_LIMIT + 44; i++) begin
            b = (i % GROUP_5 < 2) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255));
            send_byte(b, i == TRACK_LIMIT + 43);
        end
        drain_results();
    endtask

    task automatic test_random_tracks();
        int unsigned sent;
        int unsigned len;
        int unsigned gsize;
        logic [7:0]  b;
        sent = 0;
        while (sent < 220) begin
            if ($urandom_range(0, 2) == 0) begin
                drain_results();
                set_char_format($urandom_range(0, 1) ? FMT_5BIT : FMT_7BIT);
            end
            gaps_off = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 36);
            gsize = (fmt_q == FMT_5BIT) ? GROUP_5 : GROUP_7;
            for (int i = 0; i < len; i++) begin
                if (i % gsize < 2) begin
                    b = ($urandom_range(0, 24) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                send_byte(b, i == len - 1);
            end
            sent += len;
        end
        gaps_off = 1'b0;
        drain_results();
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        test_seven_bit_groups();
        test_end_on_group();
        test_halt_on_zero();
        test_five_bit_groups();
        test_format_switch();
        test_overlong_track();
        test_random_tracks();

        drain_results();
        if (errors == 0 && pending_chars.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
